FILE: sv/skt_pkg.sv
// Package for the sorted key table: transaction payload types, opcodes,
// controller states and the control bundle that drives the row of cells.
// No dependencies.
package skt_pkg;

  localparam int KEY_W     = 32;
  localparam int POS_W     = 7;
  localparam int ENTRIES_W = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [KEY_W-1:0] search_key;
    logic signed [KEY_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [POS_W-1:0]     position;
    logic [ENTRIES_W-1:0] entries_held;
  } rsp_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPARE,
    S_SEARCH,
    S_INSERT,
    S_DELETE,
    S_DONE
  } state_t;

endpackage

FILE: sv/sorted_key_table.sv
// Sorted key table: a row of CAPACITY cells kept in signed key order and a
// controller that runs insert, delete and lookup over it; depends on skt_pkg and skt_cell.
// Insert runs compare, insert shift and done; a full-table insert or an unused opcode goes
// straight to done. Lookup and delete run compare and a binary search, then a shift for a found
// delete, then done. One transaction in flight; a stalled response holds it.
// Reset empties the table by clearing the entry count; there is no clearing pass.
module sorted_key_table #(
  parameter int CAPACITY = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  skt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output skt_pkg::rsp_t rsp
);
  import skt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t state;
  state_t state_next;
  cell_ctl_t ctl;

  logic [1:0]              op;
  logic signed [KEY_W-1:0] op_key;
  logic signed [KEY_W-1:0] op_value;
  logic [CW-1:0]           count;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hip1;
  logic                    res_ok;
  logic [IW-1:0]           res_pos;

  logic signed [KEY_W-1:0] key_arr [CAPACITY];
  logic signed [KEY_W-1:0] val_arr [CAPACITY];
  logic [CAPACITY-1:0]     gt_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     lt_vec;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_wide;
  logic [IW-1:0] mid;
  logic          search_live;
  logic          req_fire;
  logic          rsp_free;

  assign mid_sum     = {1'b0, lo} + {1'b0, hip1} - (CW + 1)'(1);
  assign mid_wide    = CW'(mid_sum >> 1);
  assign mid         = mid_wide[IW-1:0];
  assign search_live = lo < hip1;
  assign req_fire    = req_valid && req_ready;
  assign rsp_free    = !rsp_valid || rsp_ready;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [KEY_W-1:0] left_key;
      logic signed [KEY_W-1:0] left_value;
      logic                    left_gt;
      logic signed [KEY_W-1:0] right_key;
      logic signed [KEY_W-1:0] right_value;

      if (g == 0) begin : g_first
        assign left_key   = '0;
        assign left_value = '0;
        assign left_gt    = 1'b0;
      end else begin : g_inner_left
        assign left_key   = key_arr[g-1];
        assign left_value = val_arr[g-1];
        assign left_gt    = gt_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_key   = key_arr[g];
        assign right_value = val_arr[g];
      end else begin : g_inner_right
        assign right_key   = key_arr[g+1];
        assign right_value = val_arr[g+1];
      end

      skt_cell #(
        .INDEX(g),
        .CW   (CW),
        .IW   (IW)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count),
        .del_pos    (res_pos),
        .op_key     (op_key),
        .op_value   (op_value),
        .left_key   (left_key),
        .left_value (left_value),
        .left_gt    (left_gt),
        .right_key  (right_key),
        .right_value(right_value),
        .key        (key_arr[g]),
        .value      (val_arr[g]),
        .gt         (gt_vec[g]),
        .eq         (eq_vec[g]),
        .lt         (lt_vec[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.opcode == OP_INSERT) begin
            state_next = (count < CW'(CAPACITY)) ? S_COMPARE : S_DONE;
          end else if (req.opcode == OP_DELETE || req.opcode == OP_LOOKUP) begin
            state_next = S_COMPARE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_COMPARE: state_next = (op == OP_INSERT) ? S_INSERT : S_SEARCH;
      S_SEARCH: begin
        if (!search_live) begin
          state_next = S_DONE;
        end else if (eq_vec[mid]) begin
          state_next = (op == OP_DELETE) ? S_DELETE : S_DONE;
        end
      end
      S_INSERT: state_next = S_DONE;
      S_DELETE: state_next = S_DONE;
      S_DONE:   state_next = rsp_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = state == S_IDLE;
    ctl.cmp   = state == S_COMPARE;
    ctl.ins   = state == S_INSERT;
    ctl.del   = state == S_DELETE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            op       <= req.opcode;
            op_key   <= req.search_key;
            op_value <= req.entry_value;
            lo       <= '0;
            hip1     <= count;
            res_ok   <= 1'b0;
            res_pos  <= '0;
          end
        end
        S_SEARCH: begin
          if (search_live) begin
            if (eq_vec[mid]) begin
              res_ok  <= 1'b1;
              res_pos <= mid;
              lo      <= hip1;
            end else if (lt_vec[mid]) begin
              lo <= mid_wide + CW'(1);
            end else begin
              hip1 <= mid_wide;
            end
          end
        end
        S_INSERT: begin
          count  <= count + CW'(1);
          res_ok <= 1'b1;
        end
        S_DELETE: count <= count - CW'(1);
        S_DONE: begin
          if (rsp_free) begin
            rsp.ok           <= res_ok;
            rsp.position     <= (res_ok && op != OP_INSERT) ? POS_W'(res_pos) : '0;
            rsp.entries_held <= ENTRIES_W'(count);
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_probe_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && search_live) |-> (mid_wide < count))
    else $error("search probe outside held entries");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the table");

  a_delete_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_DELETE) |-> (res_ok && op == OP_DELETE))
    else $error("delete shift without a found key");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state != S_IDLE))
    else $error("controller idle after accepting a transaction");

endmodule

FILE: sv/skt_cell.sv
// One cell of the sorted key table: holds one key and value, compares the key
// with the operation key and shifts towards either neighbour.
// Depends on skt_pkg.
module skt_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 8,
  parameter int IW    = 7
) (
  input  logic                            clk,
  input  skt_pkg::cell_ctl_t              ctl,
  input  logic [CW-1:0]                   count,
  input  logic [IW-1:0]                   del_pos,
  input  logic signed [skt_pkg::KEY_W-1:0] op_key,
  input  logic signed [skt_pkg::KEY_W-1:0] op_value,
  input  logic signed [skt_pkg::KEY_W-1:0] left_key,
  input  logic signed [skt_pkg::KEY_W-1:0] left_value,
  input  logic                            left_gt,
  input  logic signed [skt_pkg::KEY_W-1:0] right_key,
  input  logic signed [skt_pkg::KEY_W-1:0] right_value,
  output logic signed [skt_pkg::KEY_W-1:0] key,
  output logic signed [skt_pkg::KEY_W-1:0] value,
  output logic                            gt,
  output logic                            eq,
  output logic                            lt
);
  import skt_pkg::*;

  logic held;
  logic at_end;
  logic above_pos;

  assign held      = CW'(INDEX) < count;
  assign at_end    = CW'(INDEX) == count;
  assign above_pos = IW'(INDEX) >= del_pos;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      eq <= key == op_key;
      lt <= key < op_key;
      gt <= held && (op_key < key);
    end
    if (ctl.ins) begin
      if (left_gt) begin
        key   <= left_key;
        value <= left_value;
      end else if (gt || at_end) begin
        key   <= op_key;
        value <= op_value;
      end
    end else if (ctl.del && above_pos) begin
      key   <= right_key;
      value <= right_value;
    end
  end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for sorted_key_table: directed and random insert,
// delete, lookup and unused-opcode transactions, each checked against a
// behavioural table model. Depends on skt_pkg and the sorted_key_table RTL.
`timescale 1ns / 1ps

module testbench;
  import skt_pkg::*;

  localparam int CAPACITY       = 128;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  req_t  pending_reqs[$];
  rsp_t  expected_rsps[$];
  logic signed [KEY_W-1:0] issued_keys[$];
  logic signed [KEY_W-1:0] key_pool[16];

  logic signed [KEY_W-1:0] table_keys[CAPACITY];
  logic signed [KEY_W-1:0] table_vals[CAPACITY];
  int held_count = 0;

  int send_gap_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int idle_cycles = 0;

  sorted_key_table #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int search_index(logic signed [KEY_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = held_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_keys[mid] == k) return mid;
      if (table_keys[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t res;
    int idx;
    res = '0;
    case (r.opcode)
      OP_INSERT: begin
        if (held_count < CAPACITY) begin
          idx = held_count;
          while (idx > 0 && r.search_key < table_keys[idx-1]) begin
            table_keys[idx] = table_keys[idx-1];
            table_vals[idx] = table_vals[idx-1];
            idx--;
          end
          table_keys[idx] = r.search_key;
          table_vals[idx] = r.entry_value;
          held_count++;
          res.ok = 1'b1;
        end
      end
      OP_DELETE, OP_LOOKUP: begin
        idx = search_index(r.search_key);
        if (idx >= 0) begin
          res.ok = 1'b1;
          res.position = idx[POS_W-1:0];
          if (r.opcode == OP_DELETE) begin
            for (int i = idx; i + 1 < held_count; i++) begin
              table_keys[i] = table_keys[i+1];
              table_vals[i] = table_vals[i+1];
            end
            held_count--;
          end
        end
      end
      default: ;
    endcase
    res.entries_held = held_count[ENTRIES_W-1:0];
    return res;
  endfunction

  task automatic queue_op(logic [1:0] op, logic signed [KEY_W-1:0] k,
                          logic signed [KEY_W-1:0] v);
    pending_reqs.push_back('{opcode: op, search_key: k, entry_value: v});
    if (op == OP_INSERT) issued_keys.push_back(k);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key(bit for_insert);
    if (!for_insert && issued_keys.size() != 0 && $urandom_range(99) < 70)
      return issued_keys[$urandom_range(issued_keys.size() - 1)];
    if ($urandom_range(99) < 50) return key_pool[$urandom_range(15)];
    return $urandom;
  endfunction

  task automatic queue_random_ops(int n, int ins_pct, int del_pct, int look_pct);
    int roll;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < ins_pct) op = OP_INSERT;
      else if (roll < ins_pct + del_pct) op = OP_DELETE;
      else if (roll < ins_pct + del_pct + look_pct) op = OP_LOOKUP;
      else op = OP_UNUSED;
      queue_op(op, pick_key(op == OP_INSERT), $urandom);
    end
  endtask

  task automatic wait_for_quiet();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response transaction with none expected");
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.ok !== want.ok)
            report_mismatch($sformatf("ok got %b want %b", rsp.ok, want.ok));
          if (rsp.position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      rsp.position, want.position));
          if (rsp.entries_held !== want.entries_held)
            report_mismatch($sformatf("entries_held got %0d want %0d",
                                      rsp.entries_held, want.entries_held));
        end
      end
      if (req_valid && req_ready) expected_rsps.push_back(apply_table_op(req));
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    key_pool[5] = 32'h5555_5555;
    key_pool[6] = 32'hAAAA_AAAA;
    for (int i = 7; i < 16; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty table, unused opcode, extremes, duplicates and absent keys.
    queue_op(OP_LOOKUP, 0, 0);
    queue_op(OP_DELETE, 5, 0);
    queue_op(OP_UNUSED, KEY_MAX, KEY_MIN);
    queue_op(OP_INSERT, 0, KEY_MAX);
    queue_op(OP_INSERT, KEY_MIN, KEY_MIN);
    queue_op(OP_INSERT, KEY_MAX, -1);
    queue_op(OP_INSERT, -1, 0);
    queue_op(OP_INSERT, 0, 32'h5555_5555);
    queue_op(OP_INSERT, 0, 32'hAAAA_AAAA);
    queue_op(OP_INSERT, 32'h5555_5555, 2);
    queue_op(OP_LOOKUP, 0, 0);
    queue_op(OP_LOOKUP, KEY_MIN, 0);
    queue_op(OP_LOOKUP, KEY_MAX, 0);
    queue_op(OP_LOOKUP, -1, 0);
    queue_op(OP_LOOKUP, 1, 0);
    queue_op(OP_DELETE, KEY_MAX, 0);
    queue_op(OP_DELETE, KEY_MIN, 0);
    queue_op(OP_DELETE, 0, 0);
    queue_op(OP_DELETE, 32'hAAAA_AAAA, 0);
    queue_op(OP_UNUSED, 0, $urandom);
    queue_op(OP_DELETE, -1, 0);
    queue_op(OP_DELETE, 0, 0);
    queue_op(OP_DELETE, 32'h5555_5555, 0);
    queue_op(OP_DELETE, 0, 0);
    queue_op(OP_LOOKUP, 0, 0);

    // Insert-heavy first so that the table fills and inserts are refused.
    send_gap_pct = 0;
    stall_pct = 0;
    queue_random_ops(200, 85, 5, 8);
    wait_for_quiet();

    send_gap_pct = 47;
    stall_pct = 0;
    queue_random_ops(190, 40, 30, 25);
    wait_for_quiet();

    send_gap_pct = 0;
    stall_pct = 47;
    queue_random_ops(180, 15, 60, 20);
    wait_for_quiet();

    send_gap_pct = 10;
    stall_pct = 10;
    queue_random_ops(180, 45, 30, 20);
    wait_for_quiet();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/skt_pkg.sv
sv/skt_cell.sv
sv/sorted_key_table.sv
sim/testbench.sv
